[rtl/sapt_pkg.sv]
// Package for the sorted axis point table: request/result types, codes, cell command.
// No dependencies; imported by sapt_cell, sorted_axis_point_table_core and tb.
package sapt_pkg;

    localparam int DEFAULT_DEPTH  = 64;
    localparam int COORD_W        = 32;
    localparam int DIST_W         = 31;
    localparam int INDEX_W        = 6;
    localparam int POS_W          = 7;
    localparam int STATUS_W       = 2;

    localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_CLOSE = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CMP,
        FSM_EVAL,
        FSM_EXEC
    } fsm_t;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] coordinate;
        logic [INDEX_W-1:0]        index;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [POS_W-1:0]          position;
        logic signed [COORD_W-1:0] point_value;
        logic [POS_W-1:0]          point_count;
    } result_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                      cmp_en;
        logic                      eval_en;
        logic                      ins_en;
        logic                      rem_en;
        logic signed [COORD_W-1:0] coord;
        logic [DIST_W-1:0]         min_dist;
    } cell_cmd_t;

    // Per-cell flags registered in the evaluate step.
    typedef struct packed {
        logic hi_close;
        logic lo_close;
    } cell_flags_t;

endpackage

[rtl/sapt_cell.sv]
// One table slot: holds a point, compares it with the request, shifts with its neighbors.
// Depends on sapt_pkg.
module sapt_cell
    import sapt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CMP_W = 7
)
(
    input  logic                      clk,
    input  cell_cmd_t                 cmd,
    input  logic                      occupied,
    input  logic [CMP_W-1:0]          shift_pos,
    input  logic signed [COORD_W-1:0] prev_value,
    input  logic signed [COORD_W-1:0] next_value,
    input  logic                      prev_lt,
    input  logic                      next_lt,
    output logic signed [COORD_W-1:0] value,
    output logic                      lt,
    output logic                      bnd,
    output cell_flags_t               flags,
    output logic signed [COORD_W-1:0] sel_value
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic signed [COORD_W-1:0] value_reg;
    logic                      lt_reg;
    cell_flags_t               flags_reg;
    logic signed [COORD_W-1:0] sel_reg;

    logic signed [COORD_W:0] hi_diff;
    logic signed [COORD_W:0] lo_diff;
    logic signed [COORD_W:0] dist_ext;
    logic                    is_last_lt;

    assign hi_diff  = {value_reg[COORD_W-1], value_reg} - {cmd.coord[COORD_W-1], cmd.coord};
    assign lo_diff  = {cmd.coord[COORD_W-1], cmd.coord} - {value_reg[COORD_W-1], value_reg};
    assign dist_ext = $signed({2'b00, cmd.min_dist});

    // boundary: first slot not below the coordinate (unoccupied slots compare false)
    assign bnd        = !lt_reg && prev_lt;
    assign is_last_lt = lt_reg && !next_lt;

    always_ff @(posedge clk)
    begin
        if (cmd.cmp_en)
        begin
            lt_reg <= occupied && (value_reg < cmd.coord);
        end
        if (cmd.eval_en)
        begin
            flags_reg.hi_close <= bnd && occupied && !(hi_diff > dist_ext);
            flags_reg.lo_close <= is_last_lt && !(lo_diff > dist_ext);
            sel_reg            <= (bnd && occupied) ? value_reg : '0;
        end
        if (cmd.ins_en)
        begin
            if (MY_IDX == shift_pos)
            begin
                value_reg <= cmd.coord;
            end
            else if (MY_IDX > shift_pos)
            begin
                value_reg <= prev_value;
            end
        end
        else if (cmd.rem_en)
        begin
            if (MY_IDX >= shift_pos)
            begin
                value_reg <= next_value;
            end
        end
    end

    assign value     = value_reg;
    assign lt        = lt_reg;
    assign flags     = flags_reg;
    assign sel_value = sel_reg;

endmodule

[rtl/sorted_axis_point_table_core.sv]
// Top level of the sorted axis point table: controller plus a row of sapt_cell slots.
// Depends on sapt_pkg and sapt_cell.
//
// Keeps up to TABLE_DEPTH signed Q16.16 points in strictly ascending order, one point per
// cell. A request is taken when start is high and busy is low; every request gives exactly
// one result, shown on result for a single cycle with result_valid high. The receiver
// cannot stall the block, so the result must be captured in that cycle. Each request passes
// from acceptance to result through these steps: compare in every cell, evaluate the boundary
// and neighbor distances, execute (shift the row one slot and update the count), then the
// result register. busy stays high through the compare, evaluate and execute steps and the
// next request may be started in the cycle the result is shown. The request rate is set by
// this fixed four-step sequence over the cell row, independent of how many points are stored.
// The minimum separation is written through the cfg channel (always ready) and must only
// change while the block is idle; its reset value is one LSB. Entries above the stored count
// are never read, so the cells need no clearing after reset; clear just zeroes the count.
module sorted_axis_point_table_core
    import sapt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  request_t          request,
    output logic              result_valid,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIST_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    fsm_t              state_reg, state_next;
    request_t          req_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIST_W-1:0] min_dist_reg;
    logic [CMP_W-1:0]  pos_reg, pos_next;
    logic              result_valid_reg;
    result_t           result_reg, result_next;

    cell_cmd_t         cmd;
    logic              ins_ok;
    logic              rem_ok;
    logic [CMP_W-1:0]  shift_pos;
    logic [CMP_W-1:0]  index_ext;
    logic [CMP_W-1:0]  count_ext;

    logic signed [COORD_W-1:0] cell_value [TABLE_DEPTH];
    logic signed [COORD_W-1:0] cell_sel   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    cell_lt;
    logic [TABLE_DEPTH-1:0]    cell_bnd;
    logic [TABLE_DEPTH-1:0]    occupied;
    cell_flags_t               cell_flags [TABLE_DEPTH];

    logic                      too_close;
    logic signed [COORD_W-1:0] found_value;

    assign index_ext = CMP_W'(req_reg.index);
    assign count_ext = CMP_W'(count_reg);

    // ---------------- cell row ----------------
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic signed [COORD_W-1:0] prev_v;
            logic signed [COORD_W-1:0] next_v;
            logic                      prev_l;
            logic                      next_l;

            if (g == 0)
            begin : g_first
                assign prev_v = '0;
                assign prev_l = 1'b1;
            end
            else
            begin : g_mid_lo
                assign prev_v = cell_value[g-1];
                assign prev_l = cell_lt[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign next_v = cell_value[g];
                assign next_l = 1'b0;
            end
            else
            begin : g_mid_hi
                assign next_v = cell_value[g+1];
                assign next_l = cell_lt[g+1];
            end

            assign occupied[g] = (CNT_W'(g) < count_reg);

            sapt_cell #(
                .IDX   (g),
                .CMP_W (CMP_W)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (occupied[g]),
                .shift_pos  (shift_pos),
                .prev_value (prev_v),
                .next_value (next_v),
                .prev_lt    (prev_l),
                .next_lt    (next_l),
                .value      (cell_value[g]),
                .lt         (cell_lt[g]),
                .bnd        (cell_bnd[g]),
                .flags      (cell_flags[g]),
                .sel_value  (cell_sel[g])
            );
        end
    endgenerate

    // lower-bound position: encode the one-hot boundary, or the depth when every slot is below
    always_comb
    begin
        pos_next = CMP_W'(TABLE_DEPTH);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cell_bnd[i])
            begin
                pos_next = CMP_W'(i);
            end
        end
    end

    // reduce the registered cell flags
    always_comb
    begin
        too_close   = 1'b0;
        found_value = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            too_close   = too_close | cell_flags[i].hi_close | cell_flags[i].lo_close;
            found_value = found_value | cell_sel[i];
        end
    end

    assign ins_ok    = (req_reg.op == OP_INSERT) && !too_close && (count_reg != FULL_COUNT);
    assign rem_ok    = (req_reg.op == OP_REMOVE) && (index_ext < count_ext);
    assign shift_pos = (req_reg.op == OP_REMOVE) ? index_ext : pos_reg;

    // ---------------- controller ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_CMP;
                end
            end
            FSM_CMP:  state_next = FSM_EVAL;
            FSM_EVAL: state_next = FSM_EXEC;
            FSM_EXEC: state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.coord    = req_reg.coordinate;
        cmd.min_dist = min_dist_reg;
        busy         = 1'b1;
        case (state_reg)
            FSM_IDLE: busy = 1'b0;
            FSM_CMP:  cmd.cmp_en = 1'b1;
            FSM_EVAL: cmd.eval_en = 1'b1;
            FSM_EXEC:
            begin
                cmd.ins_en = ins_ok;
                cmd.rem_en = rem_ok;
            end
            default:  busy = 1'b1;
        endcase
    end

    // result and new count, formed in the execute step
    always_comb
    begin
        count_next              = count_reg;
        result_next.status      = ST_OK;
        result_next.position    = POS_W'(pos_reg);
        result_next.point_value = '0;
        case (req_reg.op)
            OP_INSERT:
            begin
                if (too_close)
                begin
                    result_next.status = ST_TOO_CLOSE;
                end
                else if (count_reg == FULL_COUNT)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_FIND:
            begin
                result_next.point_value = found_value;
            end
            OP_REMOVE:
            begin
                result_next.position = POS_W'(req_reg.index);
                if (rem_ok)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    result_next.status = ST_BAD_INDEX;
                end
            end
            OP_CLEAR:
            begin
                result_next.position = '0;
                count_next           = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result_next.point_count = POS_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= FSM_IDLE;
            count_reg        <= '0;
            min_dist_reg     <= MIN_DIST_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == FSM_EXEC);
            if (state_reg == FSM_EXEC)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid)
            begin
                min_dist_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_IDLE && start)
        begin
            req_reg <= request;
        end
        if (state_reg == FSM_EVAL)
        begin
            pos_reg <= pos_next;
        end
        if (state_reg == FSM_EXEC)
        begin
            result_reg <= result_next;
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_axis_point_table_core: directed, full-table and random
// request streams against an in-bench model of the sorted point table.
// Depends on sapt_pkg and the RTL of sorted_axis_point_table_core.
module tb;
    import sapt_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam longint LONG_MAX = 64'sd2147483647;
    localparam longint LONG_MIN = -64'sd2147483648;
    localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    request_t          request = '0;
    logic              result_valid;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DIST_W-1:0] cfg_data = '0;

    // Model of the table, kept in step with accepted requests.
    longint            axis_pts [DEPTH];
    int                axis_count = 0;
    logic [DIST_W-1:0] model_min_dist = MIN_DIST_RESET;

    result_t           pending_results [$];
    int                n_errors = 0;
    int                n_results = 0;
    int                op_hits [4] = '{0, 0, 0, 0};
    int                status_hits [4] = '{0, 0, 0, 0};
    int                sender_idle_pct = 0;

    sorted_axis_point_table_core #(.TABLE_DEPTH(DEPTH)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one request to the model and returns the result it must produce.
    function automatic result_t apply_to_axis_model(request_t rq);
        result_t r;
        longint  c;
        longint  dlim;
        int      p;
        int      i;
        bit      ok;
        r = '0;
        c = longint'($signed(rq.coordinate));
        dlim = longint'(model_min_dist);
        p = 0;
        while (p < axis_count && axis_pts[p] < c)
            p++;
        case (op_t'(rq.op))
            OP_INSERT:
            begin
                r.position = POS_W'(p);
                ok = 1'b1;
                // differences in 64 bits: no wrap between far-apart points
                if (p < axis_count && !(axis_pts[p] - c > dlim))
                    ok = 1'b0;
                if (p > 0 && !(c - axis_pts[p-1] > dlim))
                    ok = 1'b0;
                if (!ok)
                    r.status = ST_TOO_CLOSE;
                else if (axis_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = axis_count; i > p; i--)
                        axis_pts[i] = axis_pts[i-1];
                    axis_pts[p] = c;
                    axis_count++;
                end
            end
            OP_FIND:
            begin
                r.position = POS_W'(p);
                if (p < axis_count)
                    r.point_value = COORD_W'(axis_pts[p]);
            end
            OP_REMOVE:
            begin
                r.position = POS_W'(rq.index);
                if (int'(rq.index) >= axis_count)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    for (i = int'(rq.index); i + 1 < axis_count; i++)
                        axis_pts[i] = axis_pts[i+1];
                    axis_count--;
                end
            end
            default:
                axis_count = 0;
        endcase
        r.point_count = POS_W'(axis_count);
        return r;
    endfunction

    // Sampled at the rising edge: all drivers use nonblocking updates, so these are
    // the values that the DUT saw at this edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor_blk
        result_t want;
        if (!rst_n)
        begin
            axis_count = 0;
            model_min_dist = MIN_DIST_RESET;
        end
        else
        begin
            if (result_valid)
            begin
                n_results++;
                status_hits[result.status]++;
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t ERROR unexpected result: expected none, actual %p",
                             $time, result);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        n_errors++;
                        $display("%0t ERROR status: expected %0d actual %0d",
                                 $time, want.status, result.status);
                    end
                    if (result.position !== want.position)
                    begin
                        n_errors++;
                        $display("%0t ERROR position: expected %0d actual %0d",
                                 $time, want.position, result.position);
                    end
                    if (result.point_value !== want.point_value)
                    begin
                        n_errors++;
                        $display("%0t ERROR point_value: expected %0d actual %0d",
                                 $time, want.point_value, result.point_value);
                    end
                    if (result.point_count !== want.point_count)
                    begin
                        n_errors++;
                        $display("%0t ERROR point_count: expected %0d actual %0d",
                                 $time, want.point_count, result.point_count);
                    end
                end
            end
            if (start && !busy)
            begin
                op_hits[request.op]++;
                pending_results = {pending_results, apply_to_axis_model(request)};
            end
            if (cfg_valid && cfg_ready)
                model_min_dist = cfg_data;
        end
    end

    // Sends one request, with random idle cycles ahead of it; returns at the accepting edge.
    task automatic send_request(input op_t rq_op, input logic signed [COORD_W-1:0] coord,
                                input logic [INDEX_W-1:0] idx);
        request_t rq;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        rq.op = rq_op;
        rq.coordinate = coord;
        rq.index = idx;
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stops requests and waits until every expected result has come back.
    task automatic wait_until_drained();
        int n;
        start <= 1'b0;
        @(posedge clk);
        for (n = 0; n < 20000 && (pending_results.size() != 0 || busy); n++)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_separation(input logic [DIST_W-1:0] sep_val);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data <= sep_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Four times in ten near stored points (hits the too-close boundary), else anywhere.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        longint base;
        longint span;
        longint v;
        int     sel;
        sel = $urandom_range(9);
        if (sel < 4 && axis_count > 0)
        begin
            base = axis_pts[$urandom_range(0, (axis_count > DEPTH ? DEPTH : axis_count) - 1)];
            span = longint'(model_min_dist) + 2;
            v = base + (longint'($urandom) % (2 * span + 1)) - span;
            if (v > LONG_MAX)
                v = LONG_MAX;
            if (v < LONG_MIN)
                v = LONG_MIN;
            return COORD_W'(v);
        end
        else if (sel < 7)
            return $urandom;
        else if (sel < 9)
            return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
        else
            return $urandom_range(1) ? COORD_MAX : COORD_MIN;
    endfunction

    task automatic test_directed();
        sender_idle_pct = 0;
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_FIND, 0, 0);                 // empty table, past end
        send_request(OP_REMOVE, 0, 0);               // nothing to remove
        send_request(OP_REMOVE, 0, 6'd63);
        send_request(OP_INSERT, COORD_MAX, 0);
        send_request(OP_INSERT, COORD_MIN, 6'd63);
        send_request(OP_INSERT, 0, 0);
        send_request(OP_INSERT, 0, 0);               // duplicate
        send_request(OP_INSERT, 1, 0);               // exactly min separation away
        send_request(OP_INSERT, -1, 0);
        send_request(OP_INSERT, 2, 0);
        send_request(OP_INSERT, COORD_MAX - 1, 0);
        send_request(OP_FIND, COORD_MIN, 0);
        send_request(OP_FIND, 1, 0);
        send_request(OP_FIND, COORD_MAX, 0);
        send_request(OP_REMOVE, 0, 6'd3);            // drop the top entry
        send_request(OP_FIND, COORD_MAX, 0);         // now past end
        send_request(OP_REMOVE, 0, 0);
        send_request(OP_REMOVE, 0, 6'd5);            // index beyond count
        send_request(OP_CLEAR, COORD_MAX, 6'd63);
        // widest separation: only a difference of 2^31 or more clears it
        write_separation(DIST_MAX);
        send_request(OP_INSERT, COORD_MIN, 0);
        send_request(OP_INSERT, COORD_MAX, 0);
        send_request(OP_INSERT, 0, 0);
        send_request(OP_FIND, 0, 0);
        write_separation('0);
        send_request(OP_INSERT, COORD_MAX, 0);       // equal point still refused
        send_request(OP_INSERT, COORD_MAX - 1, 0);
    endtask

    task automatic test_full_table();
        int i;
        write_separation('0);
        send_request(OP_CLEAR, 0, 0);
        for (i = 0; i < DEPTH; i++)
            send_request(OP_INSERT, COORD_W'(i) * 32'h0400_0000 + 32'h8000_0000, 0);
        send_request(OP_INSERT, COORD_MAX, 0);       // acceptable but no room
        send_request(OP_INSERT, 32'h8400_0000, 0);   // too close takes priority over full
        send_request(OP_FIND, 32'h8400_0001, 0);
        send_request(OP_REMOVE, 0, 6'd10);
        send_request(OP_INSERT, 32'h8000_0000 + 32'd10 * 32'h0400_0000, 0);
        send_request(OP_REMOVE, 0, 6'd63);
        send_request(OP_REMOVE, 0, 6'd63);           // count is 63 now
    endtask

    // Insert-heavy mix so the table fills up and stays near full for a while.
    task automatic test_random(input int n_items, input int idle_pct,
                               input logic [DIST_W-1:0] sep_val);
        int   i;
        int   pick;
        op_t  rq_op;
        logic [INDEX_W-1:0] idx;
        write_separation(sep_val);
        sender_idle_pct = idle_pct;
        for (i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                rq_op = OP_INSERT;
            else if (pick < 80)
                rq_op = OP_FIND;
            else if (pick < 97)
                rq_op = OP_REMOVE;
            else
                rq_op = OP_CLEAR;
            if ($urandom_range(3) != 0 && axis_count > 0)
                idx = $urandom_range(0, (axis_count > DEPTH ? DEPTH : axis_count) - 1);
            else
                idx = INDEX_W'($urandom);
            send_request(rq_op, rand_coord(), idx);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_random(340, 0, 31'h0001_0000);
        test_random(360, 82, '0);
        test_random(340, 19, DIST_W'($urandom_range(0, 32'h0010_0000)));
        test_random(200, 0, DIST_MAX);
        wait_until_drained();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            n_errors++;
            $display("%0t ERROR %0d results never arrived", $time, pending_results.size());
        end
        $display("Covered %0d inserts, %0d finds, %0d removes, %0d clears; %0d results seen",
                 op_hits[OP_INSERT], op_hits[OP_FIND], op_hits[OP_REMOVE], op_hits[OP_CLEAR],
                 n_results);
        $display("Status mix: %0d ok, %0d too close, %0d full, %0d bad index",
                 status_hits[ST_OK], status_hits[ST_TOO_CLOSE], status_hits[ST_FULL],
                 status_hits[ST_BAD_INDEX]);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("%0t ERROR timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sorted_axis_point_table_core.f]
rtl/sapt_pkg.sv
rtl/sapt_cell.sv
rtl/sorted_axis_point_table_core.sv
tb/sv/tb.sv
